@@ src/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Action and status codes, and the control word carried along the cell row.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// number of storage cells in the row; each owns one bank of slots
	localparam int unsigned NCELLS = 4;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_READ       = 3'd4,
		ACT_CLEAR      = 3'd5,
		ACT_RESIZE     = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// memory request moving down the cell row
	typedef struct packed {
		logic vld;
		logic we;
		logic re;
	} cell_ctl_t;

endpackage

@@ src/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram: generic single-port RAM
// One address per cycle, write when we is high, read data registered.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque row
// Owns a contiguous bank of slots. Every request passes through one cell per
// cycle; the owning cell writes or reads its bank and merges read data.
// ----------------------------------------------------------------------------
module cdq_cell #(
	parameter int unsigned CELL_ID    = 0,
	parameter int unsigned BANK       = 128,
	parameter int unsigned SLOT_W     = 9,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned BANK_AW   = (BANK > 1) ? $clog2(BANK) : 1,
	localparam int unsigned LO        = CELL_ID * BANK,
	localparam int unsigned HI        = LO + BANK
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdq_pkg::cell_ctl_t    ctl_in,
	input  logic [SLOT_W-1:0]     slot_in,
	input  logic [DATA_WIDTH-1:0] wdata_in,
	input  logic [DATA_WIDTH-1:0] rdata_in,
	output cdq_pkg::cell_ctl_t    ctl_out,
	output logic [SLOT_W-1:0]     slot_out,
	output logic [DATA_WIDTH-1:0] wdata_out,
	output logic [DATA_WIDTH-1:0] rdata_out
);

	logic [31:0]           slot_ext;
	logic                  hit;
	logic [BANK_AW-1:0]    bank_addr;
	logic                  bank_we;
	logic [DATA_WIDTH-1:0] bank_rdata;

	cdq_pkg::cell_ctl_t    ctl_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  hit_rd_q;

	assign slot_ext  = 32'(slot_in);
	assign hit       = (slot_ext >= LO) && (slot_ext < HI);
	assign bank_addr = BANK_AW'(slot_ext - LO);
	assign bank_we   = ctl_in.vld && ctl_in.we && hit;

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (BANK)
	) u_bank (
		.clk   (clk),
		.we    (bank_we),
		.addr  (bank_addr),
		.wdata (wdata_in),
		.rdata (bank_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= '0;
			slot_q   <= '0;
			wdata_q  <= '0;
			rdata_q  <= '0;
			hit_rd_q <= 1'b0;
		end else begin
			ctl_q    <= ctl_in;
			slot_q   <= slot_in;
			wdata_q  <= wdata_in;
			rdata_q  <= rdata_in;
			hit_rd_q <= ctl_in.vld && ctl_in.re && hit;
		end
	end

	// bank read data lands in the cycle after the request, alongside it
	assign ctl_out   = ctl_q;
	assign slot_out  = slot_q;
	assign wdata_out = wdata_q;
	assign rdata_out = hit_rd_q ? bank_rdata : rdata_q;

endmodule

@@ src/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a circular store
// Head pointer and element count in the control section; elements live in a
// row of storage cells, each owning one bank of slots.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | fields
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | action, value, index, new_size
//  out     | out_valid/out_stall | read_data, item_count, is_empty, status
//
// Push, pop, clear, shrink and failed reads: result registered straight from the accept.
// Read: result set by the walk of the request down the cell row, cell by cell.
// Resize growth: the single write per cycle into the row adds one element each,
//   up to CAPACITY elements.
// Reset clears head and count; the store is not cleared.
// A stalled result waits in the output register; one more item may be taken
//   and its result parks in a hold register behind it.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int unsigned CAPACITY   = 512,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned SLOT_W    = $clog2(CAPACITY),
	localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            action,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [SLOT_W-1:0]     index,
	input  logic [CNT_W-1:0]      new_size,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic [CNT_W-1:0]      item_count,
	output logic                  is_empty,
	output logic [1:0]            status
);

	localparam int unsigned NC   = cdq_pkg::NCELLS;
	localparam int unsigned BANK = (CAPACITY + NC - 1) / NC;
	localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
	localparam logic [SLOT_W-1:0] LAST_S = SLOT_W'(CAPACITY - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_READ
	} state_t;

	// wrap a head-relative sum back into the store; the sum stays below 2*CAPACITY
	function automatic logic [SLOT_W-1:0] wrap(input logic [SLOT_W:0] sum);
		logic [SLOT_W:0] cap_w;
		cap_w = (SLOT_W+1)'(CAPACITY);
		if (sum >= cap_w) begin
			return SLOT_W'(sum - cap_w);
		end
		return SLOT_W'(sum);
	endfunction

	// control state
	state_t                 state_q;
	logic [SLOT_W-1:0]      head_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       target_q;
	logic [DATA_WIDTH-1:0]  fill_q;
	cdq_pkg::status_t       fstat_q;

	// request into the cell row
	cdq_pkg::cell_ctl_t     tok_ctl_q;
	logic [SLOT_W-1:0]      tok_slot_q;
	logic [DATA_WIDTH-1:0]  tok_data_q;

	// output register and hold register behind it
	logic                   out_vld_q;
	logic [DATA_WIDTH-1:0]  out_data_q;
	logic [CNT_W-1:0]       out_cnt_q;
	cdq_pkg::status_t       out_st_q;
	logic                   hold_vld_q;
	logic [DATA_WIDTH-1:0]  hold_data_q;
	logic [CNT_W-1:0]       hold_cnt_q;
	cdq_pkg::status_t       hold_st_q;

	// cell row wiring
	cdq_pkg::cell_ctl_t     ch_ctl   [NC+1];
	logic [SLOT_W-1:0]      ch_slot  [NC+1];
	logic [DATA_WIDTH-1:0]  ch_wdata [NC+1];
	logic [DATA_WIDTH-1:0]  ch_rdata [NC+1];

	// next-state and result
	logic                   acc;
	logic                   ret;
	logic                   out_free;
	logic                   full;
	state_t                 nxt_state;
	logic [SLOT_W-1:0]      nxt_head;
	logic [CNT_W-1:0]       nxt_count;
	logic [CNT_W-1:0]       nxt_target;
	logic [DATA_WIDTH-1:0]  nxt_fill;
	cdq_pkg::status_t       nxt_fstat;
	logic                   iss_vld;
	logic                   iss_we;
	logic                   iss_re;
	logic [SLOT_W-1:0]      iss_slot;
	logic [DATA_WIDTH-1:0]  iss_data;
	logic                   res_vld;
	logic [DATA_WIDTH-1:0]  res_data;
	cdq_pkg::status_t       res_st;
	logic [CNT_W-1:0]       tgt;

	// new items only in IDLE and with room for one more result
	assign in_stall = (state_q != S_IDLE) || hold_vld_q;
	assign acc      = in_valid && !in_stall;
	assign ret      = ch_ctl[NC].vld && ch_ctl[NC].re;
	assign out_free = !out_vld_q || !out_stall;
	assign full     = (count_q == CAP_C);
	assign tgt      = (new_size > CAP_C) ? CAP_C : new_size;

	always_comb begin
		nxt_state  = state_q;
		nxt_head   = head_q;
		nxt_count  = count_q;
		nxt_target = target_q;
		nxt_fill   = fill_q;
		nxt_fstat  = fstat_q;
		iss_vld    = 1'b0;
		iss_we     = 1'b0;
		iss_re     = 1'b0;
		iss_slot   = '0;
		iss_data   = value;
		res_vld    = 1'b0;
		res_data   = '0;
		res_st     = cdq_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					res_vld = 1'b1;
					case (action)
						cdq_pkg::ACT_PUSH_FRONT: begin
							if (full) begin
								res_st = cdq_pkg::ST_FULL;
							end else begin
								nxt_head  = (head_q == '0) ? LAST_S : head_q - 1'b1;
								nxt_count = count_q + 1'b1;
								iss_vld   = 1'b1;
								iss_we    = 1'b1;
								iss_slot  = nxt_head;
							end
						end
						cdq_pkg::ACT_PUSH_BACK: begin
							if (full) begin
								res_st = cdq_pkg::ST_FULL;
							end else begin
								nxt_count = count_q + 1'b1;
								iss_vld   = 1'b1;
								iss_we    = 1'b1;
								iss_slot  = wrap((SLOT_W+1)'(head_q) + (SLOT_W+1)'(count_q));
							end
						end
						cdq_pkg::ACT_POP_FRONT: begin
							if (count_q == '0) begin
								res_st = cdq_pkg::ST_EMPTY;
							end else begin
								nxt_head  = (head_q == LAST_S) ? '0 : head_q + 1'b1;
								nxt_count = count_q - 1'b1;
							end
						end
						cdq_pkg::ACT_POP_BACK: begin
							if (count_q == '0) begin
								res_st = cdq_pkg::ST_EMPTY;
							end else begin
								nxt_count = count_q - 1'b1;
							end
						end
						cdq_pkg::ACT_READ: begin
							if (CNT_W'(index) >= count_q) begin
								res_st = cdq_pkg::ST_RANGE;
							end else begin
								// result comes back from the end of the row
								res_vld   = 1'b0;
								iss_vld   = 1'b1;
								iss_re    = 1'b1;
								iss_slot  = wrap((SLOT_W+1)'(head_q) + (SLOT_W+1)'(index));
								nxt_state = S_READ;
							end
						end
						cdq_pkg::ACT_CLEAR: begin
							nxt_head  = '0;
							nxt_count = '0;
						end
						cdq_pkg::ACT_RESIZE: begin
							if (new_size > CAP_C) begin
								res_st = cdq_pkg::ST_FULL;
							end
							if (tgt > count_q) begin
								res_vld    = 1'b0;
								nxt_target = tgt;
								nxt_fill   = value;
								nxt_fstat  = (new_size > CAP_C) ? cdq_pkg::ST_FULL
								                                : cdq_pkg::ST_OK;
								nxt_state  = S_FILL;
							end else begin
								nxt_count = tgt;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_FILL: begin
				// one new back slot per cycle
				iss_vld   = 1'b1;
				iss_we    = 1'b1;
				iss_slot  = wrap((SLOT_W+1)'(head_q) + (SLOT_W+1)'(count_q));
				iss_data  = fill_q;
				nxt_count = count_q + 1'b1;
				if (nxt_count == target_q) begin
					res_vld   = 1'b1;
					res_st    = fstat_q;
					nxt_state = S_IDLE;
				end
			end
			S_READ: begin
				if (ret) begin
					res_vld   = 1'b1;
					res_data  = ch_rdata[NC];
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			target_q    <= '0;
			fill_q      <= '0;
			fstat_q     <= cdq_pkg::ST_OK;
			tok_ctl_q   <= '0;
			tok_slot_q  <= '0;
			tok_data_q  <= '0;
			out_vld_q   <= 1'b0;
			out_data_q  <= '0;
			out_cnt_q   <= '0;
			out_st_q    <= cdq_pkg::ST_OK;
			hold_vld_q  <= 1'b0;
			hold_data_q <= '0;
			hold_cnt_q  <= '0;
			hold_st_q   <= cdq_pkg::ST_OK;
		end else begin
			state_q    <= nxt_state;
			head_q     <= nxt_head;
			count_q    <= nxt_count;
			target_q   <= nxt_target;
			fill_q     <= nxt_fill;
			fstat_q    <= nxt_fstat;
			tok_ctl_q  <= '{vld: iss_vld, we: iss_we, re: iss_re};
			tok_slot_q <= iss_slot;
			tok_data_q <= iss_data;
			// hold never coexists with a fresh result: hold blocks new items
			if (out_free) begin
				if (hold_vld_q) begin
					out_vld_q  <= 1'b1;
					out_data_q <= hold_data_q;
					out_cnt_q  <= hold_cnt_q;
					out_st_q   <= hold_st_q;
					hold_vld_q <= 1'b0;
				end else if (res_vld) begin
					out_vld_q  <= 1'b1;
					out_data_q <= res_data;
					out_cnt_q  <= nxt_count;
					out_st_q   <= res_st;
				end else begin
					out_vld_q <= 1'b0;
				end
			end else if (res_vld) begin
				hold_vld_q  <= 1'b1;
				hold_data_q <= res_data;
				hold_cnt_q  <= nxt_count;
				hold_st_q   <= res_st;
			end
		end
	end

	// cell row
	assign ch_ctl[0]   = tok_ctl_q;
	assign ch_slot[0]  = tok_slot_q;
	assign ch_wdata[0] = tok_data_q;
	assign ch_rdata[0] = '0;

	for (genvar g = 0; g < NC; g++) begin : g_cell
		cdq_cell #(
			.CELL_ID    (g),
			.BANK       (BANK),
			.SLOT_W     (SLOT_W),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ch_ctl[g]),
			.slot_in   (ch_slot[g]),
			.wdata_in  (ch_wdata[g]),
			.rdata_in  (ch_rdata[g]),
			.ctl_out   (ch_ctl[g+1]),
			.slot_out  (ch_slot[g+1]),
			.wdata_out (ch_wdata[g+1]),
			.rdata_out (ch_rdata[g+1])
		);
	end

	assign out_valid  = out_vld_q;
	assign read_data  = out_data_q;
	assign item_count = out_cnt_q;
	assign is_empty   = (out_cnt_q == '0);
	assign status     = out_st_q;

	// count never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count above capacity");

	// head stays inside the store
	a_head_rng: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_S)
		else $error("head pointer outside the store");

	// a read in flight is the only request in the row
	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && $past(state_q) == S_READ) |-> !tok_ctl_q.vld)
		else $error("request issued while a read is in flight");

	// read data returns only while waiting for it
	a_ret_state: assert property (@(posedge clk) disable iff (!arst_n)
		ret |-> state_q == S_READ)
		else $error("read return outside read wait");

	// hold register is used only behind a full output register
	a_hold_order: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> out_vld_q)
		else $error("held result with empty output register");

endmodule
